// ----- hw/rtl/trsc_pkg.sv -----
// Shared types and constants for the triple repeat soft combiner.
// Depends on nothing; imported by every RTL file of the block.
package trsc_pkg;

  // Width of the fixed stream fields.
  localparam int SYM_W     = 3;
  localparam int MAG_IN_W  = 12;
  localparam int START_W   = 8;
  localparam int SUM_OUT_W = 15;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SUM  = 1'b1
  } cmd_t;

  // One decoded input item as it sits in the command queue.
  typedef struct packed {
    cmd_t                cmd;
    logic [SYM_W-1:0]    symbol;
    logic [MAG_IN_W-1:0] magnitude;
    logic [START_W-1:0]  start;
  } item_t;

endpackage

// ----- hw/rtl/trsc_front.sv -----
// Front end of the combiner: accepts stream items and decodes them into item_t.
// Depends on trsc_pkg.
module trsc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [trsc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tuser,
  output logic                          push,
  output trsc_pkg::item_t               push_item,
  input  logic                          push_ready
);
  import trsc_pkg::*;

  logic  hold_valid;
  item_t hold_item;
  item_t dec_item;

  always_comb begin
    dec_item.cmd       = s_axis_tuser ? CMD_SUM : CMD_LOAD;
    dec_item.symbol    = s_axis_tdata[SYM_W-1:0];
    dec_item.magnitude = s_axis_tdata[SYM_W+MAG_IN_W-1:SYM_W];
    dec_item.start     = s_axis_tdata[SYM_W+MAG_IN_W+START_W-1:SYM_W+MAG_IN_W];
  end

  assign push          = hold_valid && push_ready;
  assign push_item     = hold_item;
  assign s_axis_tready = !hold_valid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      hold_item <= dec_item;
    end
  end

endmodule

// ----- hw/rtl/trsc_queue.sv -----
// Two-entry command queue between front end and sequencer.
// Depends on trsc_pkg.
module trsc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  trsc_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output trsc_pkg::item_t rd_item
);
  import trsc_pkg::*;

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_wr;
  logic        do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_item;
  end

endmodule

// ----- hw/rtl/trsc_back.sv -----
// Sequencer of the combiner: soft-bit ring memory, loads, combined sums, output register.
// Depends on trsc_pkg.
module trsc_back #(
  parameter int WORD_BITS = 49,
  parameter int MAG_BITS  = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  trsc_pkg::item_t                  q_item,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [trsc_pkg::SUM_OUT_W-1:0]   soft_sum,
  output logic                             m_axis_tlast
);
  import trsc_pkg::*;

  localparam int RING_LEN = 3 * WORD_BITS;
  localparam int AW       = $clog2(RING_LEN);
  localparam int EW       = MAG_BITS + 1;
  localparam int SUM_W    = MAG_BITS + 3;
  localparam int EXT_W    = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
  localparam int MX_W     = (MAG_BITS > MAG_IN_W) ? MAG_BITS : MAG_IN_W;
  localparam int KW       = $clog2(WORD_BITS + 1);
  localparam logic [START_W-1:0] RING_LEN_S = START_W'(RING_LEN);
  localparam logic [AW:0]        RING_LEN_A = (AW+1)'(RING_LEN);
  localparam logic [AW:0]        WORD_A     = (AW+1)'(WORD_BITS);
  localparam logic [KW-1:0]      LAST_K     = KW'(WORD_BITS - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOAD   = 4'b0010,
    ST_REDUCE = 4'b0100,
    ST_SUM    = 4'b1000
  } state_t;

  state_t state;

  // ring storage; valid bits stand in for the all-zero reset
  logic signed [EW-1:0] ring [RING_LEN];
  logic [RING_LEN-1:0]  ring_vld;

  logic [AW-1:0]        write_pos;
  logic [SYM_W-1:0]     sym_sh;
  logic [MAG_BITS-1:0]  mag_q;
  logic [1:0]           lcnt;
  logic [START_W-1:0]   base;
  logic [AW-1:0]        bpos;
  logic [AW-1:0]        apos;
  logic [1:0]           ph;
  logic [KW-1:0]        kcnt;
  logic signed [SUM_W-1:0] acc;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic signed [EW-1:0] rd_data;
  logic                 rd_vld;
  logic signed [EW-1:0] rd_val;

  logic [MX_W-1:0]      mag_ext;
  logic signed [EW-1:0] pos_val;
  logic signed [EW-1:0] wr_val;
  logic                 wr_en;
  logic [AW:0]          step_sum;
  logic [AW-1:0]        apos_next;
  logic [AW-1:0]        bpos_next;
  logic signed [SUM_W-1:0] total;
  logic signed [EXT_W-1:0] total_ext;
  logic                 out_free;
  logic                 emit;

  assign mag_ext = MX_W'(q_item.magnitude);
  assign pos_val = $signed({1'b0, mag_q});
  assign wr_val  = sym_sh[SYM_W-1] ? pos_val : -pos_val;
  assign wr_en   = (state == ST_LOAD);

  assign q_ready = (state == ST_IDLE);

  // next ring positions, wrapped: one word further on for apos, one entry on for bpos
  always_comb begin
    step_sum = ((ph == 2'd0) ? {1'b0, bpos} : {1'b0, apos}) + WORD_A;
    if (step_sum >= RING_LEN_A) begin
      apos_next = AW'(step_sum - RING_LEN_A);
    end else begin
      apos_next = step_sum[AW-1:0];
    end
    if ({1'b0, bpos} + (AW+1)'(1) >= RING_LEN_A) begin
      bpos_next = '0;
    end else begin
      bpos_next = bpos + AW'(1);
    end
  end

  always_comb begin
    rd_en   = (state == ST_SUM) && (ph != 2'd3);
    rd_addr = (ph == 2'd0) ? bpos : apos;
  end

  assign rd_val    = rd_vld ? rd_data : '0;
  assign total     = acc + SUM_W'(rd_val);
  assign total_ext = EXT_W'(total);
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign emit      = (state == ST_SUM) && (ph == 2'd3) && out_free;

  always_ff @(posedge clk) begin
    if (wr_en) ring[write_pos] <= wr_val;
    if (rd_en) begin
      rd_data <= ring[rd_addr];
      rd_vld  <= ring_vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld <= '0;
    end else if (wr_en) begin
      ring_vld[write_pos] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      write_pos <= '0;
      lcnt      <= 2'd0;
      ph        <= 2'd0;
      kcnt      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.cmd == CMD_LOAD) begin
              lcnt  <= 2'd0;
              state <= ST_LOAD;
            end else begin
              state <= ST_REDUCE;
            end
          end
        end
        ST_LOAD: begin
          if ({1'b0, write_pos} + (AW+1)'(1) >= RING_LEN_A) begin
            write_pos <= '0;
          end else begin
            write_pos <= write_pos + AW'(1);
          end
          lcnt <= lcnt + 2'd1;
          if (lcnt == 2'd2) state <= ST_IDLE;
        end
        ST_REDUCE: begin
          if (base < RING_LEN_S) begin
            ph    <= 2'd0;
            kcnt  <= '0;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (ph != 2'd3) begin
            ph <= ph + 2'd1;
          end else if (out_free) begin
            ph   <= 2'd0;
            kcnt <= kcnt + KW'(1);
            if (kcnt == LAST_K) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sym_sh <= q_item.symbol;
        mag_q  <= mag_ext[MAG_BITS-1:0];
        base   <= q_item.start;
      end
      ST_LOAD: begin
        sym_sh <= {sym_sh[SYM_W-2:0], 1'b0};
      end
      ST_REDUCE: begin
        if (base >= RING_LEN_S) begin
          base <= base - RING_LEN_S;
        end else begin
          bpos <= base[AW-1:0];
        end
      end
      ST_SUM: begin
        case (ph)
          2'd0: apos <= apos_next;
          2'd1: begin
            apos <= apos_next;
            acc  <= SUM_W'(rd_val);
          end
          2'd2: acc <= total;
          default: begin
            if (out_free) bpos <= bpos_next;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      soft_sum     <= total_ext[SUM_OUT_W-1:0];
      m_axis_tlast <= (kcnt == LAST_K);
    end
  end

endmodule

// ----- hw/rtl/triple_repeat_soft_combiner.sv -----
// Top level of the rate 1/3 repetition code soft-decision combiner.
// Depends on trsc_pkg, trsc_front, trsc_queue and trsc_back.

// The block keeps a ring of 3*WORD_BITS signed soft bits. A load item (tuser low)
// writes three entries, symbol bit 2 first, each +magnitude for a one and
// -magnitude for a zero; a sum item (tuser high) returns WORD_BITS combined sums,
// each the total of the three copies WORD_BITS apart, the last one with tlast.
// Items pass a one-item input register and a two-item queue, so the input keeps
// accepting while the sequencer works. The sequencer owns the single-port ring
// memory and sets the rate; it takes a new item from the queue only when idle.
// A load takes the item, then makes one memory write per entry. A sum takes the
// item, subtracts RING_LEN from start_req while it is not below RING_LEN, makes
// a setup step and then three reads and one add per result; each result may
// also wait on m_axis_tready.
// The ring reads as zero after reset; no clearing pass is needed.
module triple_repeat_soft_combiner #(
  parameter int WORD_BITS = 49,
  parameter int MAG_BITS  = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // symbol[2:0], magnitude[14:3], start_req[22:15], zero [23]
  input  logic [trsc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // cmd: 0 load symbol, 1 request sums
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // soft_sum[14:0] (signed), zero [15]
  output logic [trsc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // last: final sum of a request
  output logic                            m_axis_tlast
);
  import trsc_pkg::*;

  logic                 push;
  logic                 push_ready;
  item_t                push_item;
  logic                 q_valid;
  logic                 q_ready;
  item_t                q_item;
  logic [SUM_OUT_W-1:0] soft_sum;

  trsc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push          (push),
    .push_item     (push_item),
    .push_ready    (push_ready)
  );

  trsc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  trsc_back #(
    .WORD_BITS (WORD_BITS),
    .MAG_BITS  (MAG_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .soft_sum      (soft_sum),
    .m_axis_tlast  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-SUM_OUT_W){1'b0}}, soft_sum};

endmodule

// ----- hw/rtl/trsc_checker.sv -----
// Port-level checks for the triple repeat soft combiner, bound to the top level.
// Depends on trsc_pkg and triple_repeat_soft_combiner.
module trsc_checker #(
  parameter int MAG_BITS = 12
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [trsc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic                            s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [trsc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);
  import trsc_pkg::*;

  localparam int MAX_SUM = 3 * ((1 << MAG_BITS) - 1);

  // a result offered stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn before it was taken");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result offered right after reset");

  // input side is open as soon as reset is released
  a_rst_in: assert property (@(posedge clk) !rst && $past(rst) |-> s_axis_tready)
    else $error("input not ready after reset");

  // three copies never sum beyond three full magnitudes
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[SUM_OUT_W-1:0]) <= MAX_SUM) &&
                      ($signed(m_axis_tdata[SUM_OUT_W-1:0]) >= -MAX_SUM))
    else $error("combined sum out of range");

endmodule

bind triple_repeat_soft_combiner trsc_checker #(.MAG_BITS(MAG_BITS)) u_trsc_checker (.*);

// ----- bench/tb_triple_repeat_soft_combiner.sv -----
// Self-checking bench for the rate 1/3 repetition soft combiner.
// Depends on trsc_pkg and triple_repeat_soft_combiner; mirrors the soft ring
// to predict every combined sum and checks each output item in order.
module tb_triple_repeat_soft_combiner;
  timeunit 1ns;
  timeprecision 1ps;

  import trsc_pkg::*;

  localparam int WORD_BITS   = 49;
  localparam int MAG_BITS    = 12;
  localparam int RING_LEN    = 3 * WORD_BITS;
  // Sequencer time for one sum request: reduction, setup, three reads and one add per sum.
  localparam int SEQ_LAT     = 4 * WORD_BITS + 8;
  // Cycles with no item moving on either side before the run is declared hung.
  localparam int STALL_LIMIT = 5000;
  localparam int IDLE_PCT    = 35;

  typedef struct {
    logic signed [SUM_OUT_W-1:0] sum;
    logic                        last;
  } combined_sum_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // symbol[2:0], magnitude[14:3], start_req[22:15], zero [23]
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // cmd: 0 load symbol, 1 request sums
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // soft_sum[14:0] (signed), zero [15]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // Shadow of the block's soft ring and its write pointer.
  logic signed [MAG_BITS:0] soft_copy [RING_LEN];
  int                       load_pos;
  combined_sum_t            sums_due [$];

  int err_cnt      = 0;
  int quiet_cycles = 0;
  int rx_hold      = 0;   // cycles the receiver must keep tready low
  bit steady       = 1'b0; // no idling on either side while set

  triple_repeat_soft_combiner #(
    .WORD_BITS(WORD_BITS),
    .MAG_BITS (MAG_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic note_error(string msg);
    err_cnt++;
    $error("%s", msg);
  endtask

  // Apply one accepted item to the shadow ring; a sum request queues the
  // WORD_BITS combined sums it must produce.
  task automatic predict_item(cmd_t cmd, logic [SYM_W-1:0] sym,
                              logic [MAG_IN_W-1:0] mag, logic [START_W-1:0] st);
    logic signed [MAG_BITS:0] soft_val;
    int                       base;
    int                       total;
    combined_sum_t            exp_sum;
    soft_val = $signed({1'b0, mag[MAG_BITS-1:0]});
    if (cmd == CMD_LOAD) begin
      // Symbol bit 2 lands first; a one is +mag, a zero is -mag.
      for (int k = 0; k < 3; k++) begin
        soft_copy[load_pos] = sym[2-k] ? soft_val : -soft_val;
        load_pos = (load_pos + 1) % RING_LEN;
      end
    end else begin
      base = st % RING_LEN;  // out-of-range starts wrap
      for (int k = 0; k < WORD_BITS; k++) begin
        total = soft_copy[(base + k) % RING_LEN]
              + soft_copy[(base + k + WORD_BITS) % RING_LEN]
              + soft_copy[(base + k + 2 * WORD_BITS) % RING_LEN];
        exp_sum.sum  = total[SUM_OUT_W-1:0];
        exp_sum.last = (k == WORD_BITS - 1);
        sums_due.push_back(exp_sum);
      end
    end
  endtask

  // Offer one item from a falling edge, with random idle cycles ahead of it unless
  // steady is set, and return at the falling edge after it is taken.
  task automatic send_item(cmd_t cmd, logic [SYM_W-1:0] sym,
                           logic [MAG_IN_W-1:0] mag, logic [START_W-1:0] st);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, st, mag, sym};
    do @(posedge clk); while (!s_axis_tready);
    predict_item(cmd, sym, mag, st);
    @(negedge clk);
  endtask

  // Random item; magnitudes lean toward the extremes now and then.
  task automatic send_random(int sum_pct);
    logic [MAG_IN_W-1:0] mag;
    case ($urandom_range(9))
      0:       mag = '0;
      1:       mag = '1;
      default: mag = MAG_IN_W'($urandom_range(4095));
    endcase
    if ($urandom_range(99) < sum_pct) begin
      send_item(CMD_SUM, SYM_W'($urandom_range(7)), mag, START_W'($urandom_range(255)));
    end else begin
      send_item(CMD_LOAD, SYM_W'($urandom_range(7)), mag, START_W'($urandom_range(255)));
    end
  endtask

  // Fresh ring reads as zero everywhere.
  task automatic test_empty_ring();
    send_item(CMD_SUM, 3'd5, 12'hfff, 8'd0);
    send_item(CMD_SUM, 3'd2, 12'h123, 8'd200);
  endtask

  // Every symbol, magnitudes at zero, one, full scale and values between.
  task automatic test_load_extremes();
    logic [MAG_IN_W-1:0] mags [8] = '{12'd4095, 12'd0, 12'd1, 12'd2048,
                                      12'd4095, 12'd2730, 12'd1365, 12'd4094};
    for (int s = 0; s < 8; s++) begin
      send_item(CMD_LOAD, s[SYM_W-1:0], mags[s], 8'hff);
    end
  endtask

  // Starts at the ring edges and beyond it; sum items carry junk fields.
  task automatic test_sum_starts();
    logic [START_W-1:0] starts [6] = '{8'd0, 8'd146, 8'd147, 8'd255, 8'd48, 8'd98};
    for (int i = 0; i < 6; i++) begin
      send_item(CMD_SUM, 3'd7, 12'hfff, starts[i]);
    end
  endtask

  // Back-to-back traffic on both sides.
  task automatic test_steady_flow();
    steady = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_random(25);
    end
    steady = 1'b0;
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the queue fills and the input stalls.
  task automatic test_output_hold();
    rx_hold = 500;
    steady  = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_random(100);
    end
    for (int i = 0; i < 4; i++) begin
      send_random(0);
    end
    steady = 1'b0;
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 420; i++) begin
      send_random(20);
    end
  endtask

  // Receiver: random tready, a forced hold when asked for.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Output check against the oldest pending sum, plus stall counting.
  always @(posedge clk) begin
    combined_sum_t exp_sum;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (sums_due.size() == 0) begin
          note_error($sformatf("unexpected item: soft_sum %0d last %0b",
                               $signed(m_axis_tdata[SUM_OUT_W-1:0]), m_axis_tlast));
        end else begin
          exp_sum = sums_due.pop_front();
          if (m_axis_tdata[SUM_OUT_W-1:0] !== exp_sum.sum) begin
            note_error($sformatf("soft_sum: expected %0d, actual %0d", exp_sum.sum,
                                 $signed(m_axis_tdata[SUM_OUT_W-1:0])));
          end
          if (m_axis_tlast !== exp_sum.last) begin
            note_error($sformatf("last: expected %0b, actual %0b",
                                 exp_sum.last, m_axis_tlast));
          end
        end
      end
    end
  end

  // Watchdog: nothing moving for too long means the block is hung.
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_triple_repeat_soft_combiner: errors");
    $finish;
  end

  initial begin
    for (int k = 0; k < RING_LEN; k++) begin
      soft_copy[k] = '0;
    end
    load_pos = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_ring();
    test_load_extremes();
    test_sum_starts();
    test_steady_flow();
    test_output_hold();
    test_random_mix();

    s_axis_tvalid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    // Let a trailing load settle and catch any stray output.
    repeat (SEQ_LAT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_triple_repeat_soft_combiner: clean");
    end else begin
      $display("tb_triple_repeat_soft_combiner: errors");
    end
    $finish;
  end

endmodule
